/* sv/ps2md_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse decoder package
// Shared widths, field positions, register codes, types and helper functions.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  // Cursor coordinate width and derived widths
  localparam int COORD_BITS = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int LIM_W      = COORD_BITS + 1;
  localparam int EXT_W      = (CFG_W > LIM_W) ? CFG_W : LIM_W;
  localparam int DELTA_W    = 9;
  localparam int SUM_W      = COORD_BITS + 2;
  localparam int BTN_W      = 3;

  // Header byte bit positions
  localparam int BTN_LEFT_BIT   = 0;
  localparam int BTN_RIGHT_BIT  = 1;
  localparam int BTN_MIDDLE_BIT = 2;
  localparam int SYNC_BIT       = 3;
  localparam int XSIGN_BIT      = 4;
  localparam int YSIGN_BIT      = 5;

  // Screen size after reset
  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(768);

  // Byte position within a packet
  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_XMOVE = 2'd1,
    PH_YMOVE = 2'd2
  } phase_e;

  // Configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             we;
    reg_idx_e         idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] xmove;
    logic [7:0] ymove;
  } packet_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [BTN_W-1:0]      down;
    logic [BTN_W-1:0]      click;
  } result_t;

  // Map a size register onto the range 1 .. 2^COORD_BITS
  function automatic logic [LIM_W-1:0] eff_limit(input logic [CFG_W-1:0] r);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] cap;
    ext = EXT_W'(r);
    cap = EXT_W'(1) << COORD_BITS;
    if (ext == '0) begin
      return LIM_W'(1);
    end else if (ext > cap) begin
      return LIM_W'(cap);
    end else begin
      return LIM_W'(ext);
    end
  endfunction

  // Clamp a signed position to 0 .. lim-1
  function automatic logic [COORD_BITS-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                      input logic [LIM_W-1:0] lim);
    logic signed [SUM_W-1:0] lim_s;
    lim_s = $signed(SUM_W'(lim));
    if (v < 0) begin
      return '0;
    end else if (v >= lim_s) begin
      return COORD_BITS'(lim - LIM_W'(1));
    end else begin
      return COORD_BITS'(v);
    end
  endfunction

  localparam logic [COORD_BITS-1:0] RESET_POS_X = COORD_BITS'(eff_limit(RESET_WIDTH) >> 1);
  localparam logic [COORD_BITS-1:0] RESET_POS_Y = COORD_BITS'(eff_limit(RESET_HEIGHT) >> 1);

endpackage

/* sv/ps2md_in_if.sv */
// ----------------------------------------------------------------------------
// PS/2 byte channel
// Valid/ready channel carrying one raw byte from the mouse.
// ----------------------------------------------------------------------------
interface ps2md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

/* sv/ps2md_out_if.sv */
// ----------------------------------------------------------------------------
// Cursor result channel
// Valid/ready channel carrying cursor position and button state.
// ----------------------------------------------------------------------------
interface ps2md_out_if import ps2md_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_down;
  logic                  right_down;
  logic                  middle_down;
  logic                  left_click;
  logic                  right_click;
  logic                  middle_click;

  modport source (output valid, output cursor_x, output cursor_y, output left_down,
                  output right_down, output middle_down, output left_click,
                  output right_click, output middle_click, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_down,
                  input right_down, input middle_down, input left_click,
                  input right_click, input middle_click, output ready);
endinterface

/* sv/ps2md_framer.sv */
// ----------------------------------------------------------------------------
// PS/2 packet framer
// Registers incoming bytes, tracks the byte position and assembles packets.
// ----------------------------------------------------------------------------
module ps2md_framer import ps2md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ps2md_in_if.sink    in_i,
  output logic        pkt_valid_o,
  output packet_t     pkt_o,
  input  logic        pkt_ready_i
);

  logic       byte_vld_q;
  logic [7:0] byte_q;
  phase_e     phase_q, phase_d;
  logic [7:0] header_q;
  logic [7:0] xmove_q;
  logic       adv;
  logic       hdr_we;
  logic       xmv_we;

  // Retire the held byte unless it closes a packet the cursor stage cannot take
  assign adv         = byte_vld_q && ((phase_q != PH_YMOVE) || pkt_ready_i);
  assign in_i.ready  = !byte_vld_q || adv;
  assign pkt_valid_o = byte_vld_q && (phase_q == PH_YMOVE);
  assign pkt_o       = '{header: header_q, xmove: xmove_q, ymove: byte_q};

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      byte_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
    end
  end

  // Next byte position
  always_comb begin
    phase_d = phase_q;
    if (adv) begin
      unique case (phase_q)
        PH_XMOVE: phase_d = PH_YMOVE;
        PH_YMOVE: phase_d = PH_HEAD;
        default:  phase_d = byte_q[SYNC_BIT] ? PH_XMOVE : PH_HEAD;
      endcase
    end
  end

  // Field capture strobes
  always_comb begin
    hdr_we = 1'b0;
    xmv_we = 1'b0;
    if (adv) begin
      unique case (phase_q)
        PH_XMOVE: xmv_we = 1'b1;
        PH_YMOVE: ;
        default:  hdr_we = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Hold header and X movement until the packet closes
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      header_q <= byte_q;
    end
    if (xmv_we) begin
      xmove_q <= byte_q;
    end
  end

endmodule

/* sv/ps2md_cursor.sv */
// ----------------------------------------------------------------------------
// Cursor update
// Holds screen size and cursor state, applies packet deltas with clamping
// and drives the result register.
// ----------------------------------------------------------------------------
module ps2md_cursor import ps2md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_i,
  input  logic        pkt_valid_i,
  input  packet_t     pkt_i,
  output logic        pkt_ready_o,
  ps2md_out_if.source out_o
);

  logic [CFG_W-1:0]        width_q, width_d;
  logic [CFG_W-1:0]        height_q, height_d;
  logic [COORD_BITS-1:0]   pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0]   pos_y_q, pos_y_d;
  logic [BTN_W-1:0]        prev_q;
  logic                    out_vld_q;
  result_t                 res_q, res_d;
  logic                    take;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [BTN_W-1:0]        btn;

  assign pkt_ready_o = !out_vld_q || out_o.ready;
  assign take        = pkt_valid_i && pkt_ready_o;

  // Build 9-bit deltas and move the cursor; screen Y points down
  assign dx    = $signed({pkt_i.header[XSIGN_BIT], pkt_i.xmove});
  assign dy    = $signed({pkt_i.header[YSIGN_BIT], pkt_i.ymove});
  assign sum_x = $signed(SUM_W'(pos_x_q)) + SUM_W'(dx);
  assign sum_y = $signed(SUM_W'(pos_y_q)) - SUM_W'(dy);
  assign btn   = pkt_i.header[BTN_W-1:0];

  assign res_d.x     = clamp_pos(sum_x, eff_limit(width_q));
  assign res_d.y     = clamp_pos(sum_y, eff_limit(height_q));
  assign res_d.down  = btn;
  assign res_d.click = btn & ~prev_q;

  // Register writes and recentering
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        REG_SCREEN_WIDTH:  width_d  = cfg_i.data;
        REG_SCREEN_HEIGHT: height_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    if (cfg_i.we) begin
      pos_x_d = COORD_BITS'(eff_limit(width_d) >> 1);
      pos_y_d = COORD_BITS'(eff_limit(height_d) >> 1);
    end else if (take) begin
      pos_x_d = res_d.x;
      pos_y_d = res_d.y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      pos_x_q  <= RESET_POS_X;
      pos_y_q  <= RESET_POS_Y;
      prev_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      if (take) begin
        prev_q <= btn;
      end
    end
  end

  // Result register: load on a packet, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pkt_ready_o) begin
      out_vld_q <= pkt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.cursor_x     = res_q.x;
  assign out_o.cursor_y     = res_q.y;
  assign out_o.left_down    = res_q.down[BTN_LEFT_BIT];
  assign out_o.right_down   = res_q.down[BTN_RIGHT_BIT];
  assign out_o.middle_down  = res_q.down[BTN_MIDDLE_BIT];
  assign out_o.left_click   = res_q.click[BTN_LEFT_BIT];
  assign out_o.right_click  = res_q.click[BTN_RIGHT_BIT];
  assign out_o.middle_click = res_q.click[BTN_MIDDLE_BIT];

endmodule

/* sv/ps2_mouse_packet_decoder_top.sv */
// Result path: the transfer of a packet's third byte loads the input register, and
// the cursor update then loads the result register, which makes the result valid.
// Throughput: one byte per cycle; each byte passes the input register, then the
// cursor update loads the result register, which stalls input only while full.
// Reset: asynchronous, active low; screen 1024x768, cursor at (512, 384),
// waiting for a header byte.
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder top level
// Frames three-byte mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_top import ps2md_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ps2md_in_if.sink             in_i,
  ps2md_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic    pkt_valid;
  logic    pkt_ready;
  packet_t pkt;
  cfg_wr_t cfg;

  assign cfg = '{we: cfg_we_i, idx: reg_idx_e'(cfg_idx_i), data: cfg_data_i};

  ps2md_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pkt_valid_o (pkt_valid),
    .pkt_o       (pkt),
    .pkt_ready_i (pkt_ready)
  );

  ps2md_cursor u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pkt_valid_i (pkt_valid),
    .pkt_i       (pkt),
    .pkt_ready_o (pkt_ready),
    .out_o       (out_o)
  );

endmodule

/* sv/ps2md_checker.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2md_checker import ps2md_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_W-1:0]      cfg_data_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] cursor_x_i,
  input logic [COORD_BITS-1:0] cursor_y_i,
  input logic                  left_down_i,
  input logic                  right_down_i,
  input logic                  middle_down_i,
  input logic                  left_click_i,
  input logic                  right_click_i,
  input logic                  middle_click_i
);

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic [BTN_W-1:0] prev_q;
  logic [BTN_W-1:0] down;
  logic [BTN_W-1:0] click;
  logic             out_xfer;

  assign down     = {middle_down_i, right_down_i, left_down_i};
  assign click    = {middle_click_i, right_click_i, left_click_i};
  assign out_xfer = out_valid_i && out_ready_i;

  // Track screen size and the buttons of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      prev_q   <= '0;
    end else begin
      if (cfg_we_i && (reg_idx_e'(cfg_idx_i) == REG_SCREEN_WIDTH)) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && (reg_idx_e'(cfg_idx_i) == REG_SCREEN_HEIGHT)) begin
        height_q <= cfg_data_i;
      end
      if (out_xfer) begin
        prev_q <= down;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cursor_x_i)
      && $stable(cursor_y_i) && $stable(down) && $stable(click))
    else $error("result changed while stalled");

  a_click_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (click == (down & ~prev_q)))
    else $error("click flags do not match button edges");

  a_x_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (LIM_W'(cursor_x_i) < eff_limit(width_q)))
    else $error("cursor x outside screen");

  a_y_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (LIM_W'(cursor_y_i) < eff_limit(height_q)))
    else $error("cursor y outside screen");

endmodule

bind ps2_mouse_packet_decoder_top ps2md_checker u_ps2md_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .cfg_idx_i      (cfg_idx_i),
  .cfg_data_i     (cfg_data_i),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .cursor_x_i     (out_o.cursor_x),
  .cursor_y_i     (out_o.cursor_y),
  .left_down_i    (out_o.left_down),
  .right_down_i   (out_o.right_down),
  .middle_down_i  (out_o.middle_down),
  .left_click_i   (out_o.left_click),
  .right_click_i  (out_o.right_click),
  .middle_click_i (out_o.middle_click)
);
